// ===== src/owtm_pkg.sv =====
// Package: shared types, codes and a helper function for the one-wire temperature master.
`timescale 1ns / 1ps

package owtm_pkg;

   localparam int TICK_COUNT_BITS_DEF = 11;
   localparam int CFG_WIDTH           = 11;
   localparam int CFG_INDEX_WIDTH     = 3;

   // Register indexes on the csr port
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_LOW        = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_WAIT     = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESENCE_HOLD    = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESENCE_TIMEOUT = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WRITE_SLOT       = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_READ_SLOT        = 3'd5;

   localparam logic [CFG_WIDTH-1:0] RESET_LOW_DEF        = 11'd550;
   localparam logic [CFG_WIDTH-1:0] RELEASE_WAIT_DEF     = 11'd40;
   localparam logic [CFG_WIDTH-1:0] PRESENCE_HOLD_DEF    = 11'd240;
   localparam logic [CFG_WIDTH-1:0] PRESENCE_TIMEOUT_DEF = 11'd1000;
   localparam logic [CFG_WIDTH-1:0] WRITE_SLOT_DEF       = 11'd40;
   localparam logic [CFG_WIDTH-1:0] READ_SLOT_DEF        = 11'd70;

   // Command codes on the mode field
   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_RESET      = 3'd1;
   localparam logic [2:0] MODE_WRITE      = 3'd2;
   localparam logic [2:0] MODE_READ       = 3'd3;
   localparam logic [2:0] MODE_CONVERT    = 3'd4;
   localparam logic [2:0] MODE_READ_TEMP  = 3'd5;

   localparam logic [7:0] ROM_SKIP_CMD    = 8'hCC;
   localparam logic [7:0] CONVERT_CMD     = 8'h44;
   localparam logic [7:0] READ_SCRATCH_CMD = 8'hBE;

   localparam logic [2:0] LAST_BIT        = 3'd7;
   localparam logic [3:0] LAST_STEP       = 4'd5;
   localparam logic [2:0] STEP_LOW_BYTE   = 3'd3;
   localparam logic [2:0] STEP_HIGH_BYTE  = 3'd4;
   localparam logic [6:0] TEMP_INT_MAX    = 7'd127;

   typedef enum logic [2:0] {
      OP_END        = 3'd0,
      OP_RESET      = 3'd1,
      OP_WR_DATA    = 3'd2,
      OP_WR_SKIP    = 3'd3,
      OP_WR_CONV    = 3'd4,
      OP_WR_SCRATCH = 3'd5,
      OP_READ       = 3'd6
   } op_type;

   typedef enum logic [10:0] {
      PH_IDLE       = 11'b000_0000_0001,
      PH_RST_LOW    = 11'b000_0000_0010,
      PH_RST_REL    = 11'b000_0000_0100,
      PH_PRES_WAIT  = 11'b000_0000_1000,
      PH_PRES_HOLD  = 11'b000_0001_0000,
      PH_WR_START   = 11'b000_0010_0000,
      PH_WR_HOLD    = 11'b000_0100_0000,
      PH_WR_RECOVER = 11'b000_1000_0000,
      PH_RD_START   = 11'b001_0000_0000,
      PH_RD_SAMPLE  = 11'b010_0000_0000,
      PH_RD_WAIT    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_ticks;
      logic [CFG_WIDTH-1:0] release_wait_ticks;
      logic [CFG_WIDTH-1:0] presence_hold_ticks;
      logic [CFG_WIDTH-1:0] presence_timeout_ticks;
      logic [CFG_WIDTH-1:0] write_slot_ticks;
      logic [CFG_WIDTH-1:0] read_slot_ticks;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       presence_missing;
      logic       temp_negative;
      logic [6:0] temp_integer;
      logic [3:0] temp_tenths;
   } result_type;

   localparam logic [3:0] TENTHS_LUT [16] = '{
      4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd9
   };

   // Operation for a given command and sequence step
   function automatic op_type prog_op(input logic [2:0] cmd, input logic [2:0] step);
      op_type op;
      op = OP_END;
      unique case (cmd)
         MODE_RESET:     if (step == 3'd0) op = OP_RESET;
         MODE_WRITE:     if (step == 3'd0) op = OP_WR_DATA;
         MODE_READ:      if (step == 3'd0) op = OP_READ;
         MODE_CONVERT: begin
            unique case (step)
               3'd0:    op = OP_RESET;
               3'd1:    op = OP_WR_SKIP;
               3'd2:    op = OP_WR_CONV;
               default: op = OP_END;
            endcase
         end
         MODE_READ_TEMP: begin
            unique case (step)
               3'd0:    op = OP_RESET;
               3'd1:    op = OP_WR_SKIP;
               3'd2:    op = OP_WR_SCRATCH;
               3'd3:    op = OP_READ;
               3'd4:    op = OP_READ;
               default: op = OP_END;
            endcase
         end
         default:        op = OP_END;
      endcase
      return op;
   endfunction

endpackage

// ===== src/owtm_if.sv =====
// Interfaces: request and response channels of the one-wire temperature master.
`timescale 1ns / 1ps

interface owtm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] data_byte;
   logic       bus_level;

   modport source (output valid, output mode, output data_byte, output bus_level,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input bus_level,
                   output ready);
endinterface

interface owtm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       presence_missing;
   logic       temp_negative;
   logic [6:0] temp_integer;
   logic [3:0] temp_tenths;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output read_data, output presence_missing, output temp_negative,
                   output temp_integer, output temp_tenths, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input read_data, input presence_missing, input temp_negative,
                   input temp_integer, input temp_tenths, output ready);
endinterface

// ===== src/owtm_cfg.sv =====
// Timing register file written through the csr port.
`timescale 1ns / 1ps

module owtm_cfg
   import owtm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CFG_RESET_LOW:        cfg_in.reset_low_ticks        = csr_wdata;
            CFG_RELEASE_WAIT:     cfg_in.release_wait_ticks     = csr_wdata;
            CFG_PRESENCE_HOLD:    cfg_in.presence_hold_ticks    = csr_wdata;
            CFG_PRESENCE_TIMEOUT: cfg_in.presence_timeout_ticks = csr_wdata;
            CFG_WRITE_SLOT:       cfg_in.write_slot_ticks       = csr_wdata;
            CFG_READ_SLOT:        cfg_in.read_slot_ticks        = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks        <= RESET_LOW_DEF;
         cfg_ff.release_wait_ticks     <= RELEASE_WAIT_DEF;
         cfg_ff.presence_hold_ticks    <= PRESENCE_HOLD_DEF;
         cfg_ff.presence_timeout_ticks <= PRESENCE_TIMEOUT_DEF;
         cfg_ff.write_slot_ticks       <= WRITE_SLOT_DEF;
         cfg_ff.read_slot_ticks        <= READ_SLOT_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/owtm_core.sv =====
// Bus sequencer: advances the one-wire state by one tick per step and forms the result.
`timescale 1ns / 1ps

module owtm_core
   import owtm_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [2:0] mode,
   input  logic [7:0] data_byte,
   input  logic       bus_level,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CmpW = ((TICK_COUNT_BITS > CFG_WIDTH) ? TICK_COUNT_BITS : CFG_WIDTH) + 1;

   typedef struct packed {
      phase_type                  phase;
      logic [TICK_COUNT_BITS-1:0] tick;
      logic [2:0]                 bit_index;
      logic [7:0]                 shift_byte;
      logic [2:0]                 seq_step;
      logic [7:0]                 low_temp_byte;
      logic                       missing;
      logic [2:0]                 cmd;
      logic [7:0]                 rd_data;
      logic                       t_neg;
      logic [6:0]                 t_int;
      logic [3:0]                 t_tenths;
      logic                       done;
   } core_state_type;

   // bits of the state below the phase field
   localparam int StRestW = $bits(core_state_type) - $bits(phase_type);

   core_state_type st_ff;
   core_state_type st_in;

   function automatic core_state_type go_idle(input core_state_type s);
      core_state_type r;
      r           = s;
      r.phase     = PH_IDLE;
      r.tick      = '0;
      r.bit_index = '0;
      r.seq_step  = '0;
      r.cmd       = MODE_NONE;
      r.done      = 1'b1;
      return r;
   endfunction

   function automatic core_state_type begin_op(input core_state_type s, input op_type op,
                                               input logic [7:0] data);
      core_state_type r;
      r           = s;
      r.tick      = '0;
      r.bit_index = '0;
      unique case (op)
         OP_RESET:      r.phase = PH_RST_LOW;
         OP_WR_DATA:    begin r.shift_byte = data;             r.phase = PH_WR_START; end
         OP_WR_SKIP:    begin r.shift_byte = ROM_SKIP_CMD;     r.phase = PH_WR_START; end
         OP_WR_CONV:    begin r.shift_byte = CONVERT_CMD;      r.phase = PH_WR_START; end
         OP_WR_SCRATCH: begin r.shift_byte = READ_SCRATCH_CMD; r.phase = PH_WR_START; end
         OP_READ:       begin r.shift_byte = '0;               r.phase = PH_RD_START; end
         default:       r = go_idle(r);
      endcase
      return r;
   endfunction

   function automatic core_state_type convert_temp(input core_state_type s,
                                                   input logic [7:0] high);
      core_state_type r;
      logic [15:0]    raw;
      logic [15:0]    mag;
      r        = s;
      raw      = {high, s.low_temp_byte};
      r.t_neg  = high[7];
      mag      = high[7] ? (16'd0 - raw) : raw;
      r.t_int  = (mag[15:4] > {5'd0, TEMP_INT_MAX}) ? TEMP_INT_MAX : mag[10:4];
      r.t_tenths = TENTHS_LUT[mag[3:0]];
      return r;
   endfunction

   function automatic core_state_type finish_op(input core_state_type s);
      core_state_type r;
      logic [3:0]     nstep;
      r = s;
      if (s.phase == PH_RD_WAIT) begin
         r.rd_data = s.shift_byte;
         if (s.cmd == MODE_READ_TEMP) begin
            if (s.seq_step == STEP_LOW_BYTE) begin
               r.low_temp_byte = s.shift_byte;
            end else if (s.seq_step == STEP_HIGH_BYTE) begin
               r = convert_temp(r, s.shift_byte);
            end
         end
      end
      nstep = {1'b0, s.seq_step} + 4'd1;
      if (s.cmd > MODE_READ_TEMP || nstep > LAST_STEP) begin
         r = go_idle(r);
      end else begin
         r.seq_step = nstep[2:0];
         r = begin_op(r, prog_op(r.cmd, nstep[2:0]), 8'd0);
      end
      return r;
   endfunction

   logic [CFG_WIDTH-1:0]       dur;
   logic [CmpW-1:0]            dur_eff;
   logic [CmpW-1:0]            tick_inc;
   logic                       hit;
   logic [TICK_COUNT_BITS-1:0] tick_adv;
   logic                       drive;
   core_state_type             s0;

   always_comb begin
      s0      = st_ff;
      s0.done = 1'b0;
      // accept a command only from idle, same tick is its first bus tick
      if (st_ff.phase == PH_IDLE && mode >= MODE_RESET && mode <= MODE_READ_TEMP) begin
         s0.cmd      = mode;
         s0.seq_step = '0;
         s0          = begin_op(s0, prog_op(mode, 3'd0), data_byte);
      end

      unique case (s0.phase)
         PH_RST_LOW:   dur = cfg.reset_low_ticks;
         PH_RST_REL:   dur = cfg.release_wait_ticks;
         PH_PRES_WAIT: dur = cfg.presence_timeout_ticks;
         PH_PRES_HOLD: dur = cfg.presence_hold_ticks;
         PH_WR_HOLD:   dur = cfg.write_slot_ticks;
         PH_RD_WAIT:   dur = cfg.read_slot_ticks;
         default:      dur = cfg.reset_low_ticks;
      endcase

      // zero duration acts as one tick; a saturated counter ends the phase
      dur_eff  = (dur == '0) ? CmpW'(1) : CmpW'(dur);
      tick_inc = CmpW'(s0.tick) + CmpW'(1);
      hit      = (tick_inc >= dur_eff) || (&s0.tick);
      tick_adv = hit ? '0 : tick_inc[TICK_COUNT_BITS-1:0];

      st_in = s0;
      drive = 1'b0;
      unique case (s0.phase)
         PH_IDLE: begin
         end
         PH_RST_LOW: begin
            drive      = 1'b1;
            st_in.tick = tick_adv;
            if (hit) st_in.phase = PH_RST_REL;
         end
         PH_RST_REL: begin
            st_in.tick = tick_adv;
            if (hit) st_in.phase = PH_PRES_WAIT;
         end
         PH_PRES_WAIT: begin
            if (!bus_level) begin
               st_in.missing = 1'b0;
               st_in.tick    = '0;
               st_in.phase   = PH_PRES_HOLD;
            end else begin
               st_in.tick = tick_adv;
               if (hit) begin
                  st_in.missing = 1'b1;
                  st_in         = go_idle(st_in);
               end
            end
         end
         PH_PRES_HOLD: begin
            st_in.tick = tick_adv;
            if (hit) st_in = finish_op(st_in);
         end
         PH_WR_START: begin
            drive       = 1'b1;
            st_in.tick  = '0;
            st_in.phase = PH_WR_HOLD;
         end
         PH_WR_HOLD: begin
            drive      = ~s0.shift_byte[s0.bit_index];
            st_in.tick = tick_adv;
            if (hit) st_in.phase = PH_WR_RECOVER;
         end
         PH_WR_RECOVER: begin
            if (s0.bit_index == LAST_BIT) begin
               st_in = finish_op(st_in);
            end else begin
               st_in.bit_index = s0.bit_index + 3'd1;
               st_in.phase     = PH_WR_START;
            end
         end
         PH_RD_START: begin
            drive       = 1'b1;
            st_in.phase = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            st_in.shift_byte = {bus_level, s0.shift_byte[7:1]};
            st_in.tick       = '0;
            st_in.phase      = PH_RD_WAIT;
         end
         PH_RD_WAIT: begin
            st_in.tick = tick_adv;
            if (hit) begin
               if (s0.bit_index == LAST_BIT) begin
                  st_in = finish_op(st_in);
               end else begin
                  st_in.bit_index = s0.bit_index + 3'd1;
                  st_in.phase     = PH_RD_START;
               end
            end
         end
         default: st_in = go_idle(st_in);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= {PH_IDLE, {StRestW{1'b0}}};
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

   assign result.drive_low        = drive;
   assign result.busy_res         = (st_in.phase != PH_IDLE);
   assign result.done_res         = st_in.done;
   assign result.read_data        = st_in.rd_data;
   assign result.presence_missing = st_in.missing;
   assign result.temp_negative    = st_in.t_neg;
   assign result.temp_integer     = st_in.t_int;
   assign result.temp_tenths      = st_in.t_tenths;

endmodule

// ===== src/one_wire_temp_sensor_master.sv =====
// Top level: one-wire temperature sensor master with request/response channels.
`timescale 1ns / 1ps

// Each request beat is one bus tick: it carries the sampled bus level and an optional
// command (reset with presence detect, write byte, read byte, start conversion, read
// temperature); each tick returns exactly one response beat with the pin drive, busy and
// done flags, the last byte read and the last converted temperature. The block takes one
// beat per clock as long as the response side keeps taking beats: a beat lands in the
// input register, the sequencer advances the bus state for that tick, and the response
// is registered in the output register before it appears on the response channel.
// Commands arriving while busy are dropped. Timing registers are counted in ticks and
// are written over the csr port; the user must write them only while the block is idle,
// as the block itself does not enforce this. A count of zero acts as one tick.
module one_wire_temp_sensor_master
   import owtm_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   owtm_req_if.sink                   req_bus,
   owtm_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff;
   logic [2:0] mode_ff;
   logic [7:0] data_byte_ff;
   logic       bus_level_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       fire;

   // process a held beat when the output slot is free or being emptied
   assign fire          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || fire;

   owtm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owtm_core #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (fire),
      .mode      (mode_ff),
      .data_byte (data_byte_ff),
      .bus_level (bus_level_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         mode_ff      <= req_bus.mode;
         data_byte_ff <= req_bus.data_byte;
         bus_level_ff <= req_bus.bus_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.drive_low        = out_ff.drive_low;
   assign rsp_bus.busy_res         = out_ff.busy_res;
   assign rsp_bus.done_res         = out_ff.done_res;
   assign rsp_bus.read_data        = out_ff.read_data;
   assign rsp_bus.presence_missing = out_ff.presence_missing;
   assign rsp_bus.temp_negative    = out_ff.temp_negative;
   assign rsp_bus.temp_integer     = out_ff.temp_integer;
   assign rsp_bus.temp_tenths      = out_ff.temp_tenths;

endmodule
